FILE: sv/qxm_pkg.sv
// Shared types, constants and helpers for the quad-X mixer with PWM duty conversion.
package qxm_pkg;

    // Field widths
    localparam int PULSE_W  = 12;   // pulse-width registers, microseconds
    localparam int CORR_W   = 10;   // correction limit register
    localparam int CMD_W    = 16;   // signed input fields
    localparam int DUTY_W   = 14;   // duty output fields
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Duty conversion settings
    localparam int DUTY_BITS       = 14;
    localparam int FRAME_PERIOD_US = 20000;

    // duty = floor((p * 2*DMAX + PERIOD) / (2*PERIOD)), done as a multiply by an
    // exact reciprocal: RECIP = ceil(2^SHIFT / DIV) is exact for numerators < 2^NUM_W.
    localparam longint unsigned DUTY_MAX  = (64'd1 << DUTY_BITS) - 64'd1;
    localparam longint unsigned TWO_DMAX  = 64'd2 * DUTY_MAX;
    localparam longint unsigned DIV       = 64'd2 * FRAME_PERIOD_US;
    localparam longint unsigned PULSE_MAX = (64'd1 << PULSE_W) - 64'd1;
    localparam longint unsigned NUM_MAX   = PULSE_MAX * TWO_DMAX + FRAME_PERIOD_US;
    localparam int              NUM_W     = $clog2(NUM_MAX + 64'd1);
    localparam int              SHIFT     = NUM_W + $clog2(DIV);
    localparam longint unsigned RECIP     = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
    localparam int              RECIP_W   = NUM_W + 1;
    localparam int              PROD_W    = NUM_W + RECIP_W;

    // Signed working width of the mixer: holds any 16-bit input and any sum
    localparam int MIX_W = 17;
    typedef logic signed [MIX_W-1:0] t_mix;

    typedef enum logic [OP_W-1:0] {
        OP_MIX  = 2'd0,
        OP_ARM  = 2'd1,
        OP_STOP = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PULSE   = 3'd0,
        CFG_MAX_PULSE   = 3'd1,
        CFG_THR_FLOOR   = 3'd2,
        CFG_THR_CEILING = 3'd3,
        CFG_CORR_LIMIT  = 3'd4,
        CFG_MIX_FLOOR   = 3'd5,
        CFG_MIX_CEILING = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] thr_floor;
        logic [PULSE_W-1:0] thr_ceiling;
        logic [CORR_W-1:0]  corr_limit;
        logic [PULSE_W-1:0] mix_floor;
        logic [PULSE_W-1:0] mix_ceiling;
    } t_cfg;

    // Four motor pulses plus the armed flag that goes with them
    typedef struct packed {
        logic [PULSE_W-1:0] front_left;
        logic [PULSE_W-1:0] front_right;
        logic [PULSE_W-1:0] rear_left;
        logic [PULSE_W-1:0] rear_right;
        logic               armed;
    } t_pulse_set;

    // Lower bound is tested first, so crossed bounds give the lower bound
    function automatic t_mix clamp_s(input t_mix x, input t_mix lo, input t_mix hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic t_mix from_pulse(input logic [PULSE_W-1:0] v);
        return $signed({{(MIX_W-PULSE_W){1'b0}}, v});
    endfunction

endpackage

FILE: sv/qxm_cfg.sv
// Configuration register file of the mixer.
module qxm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qxm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qxm_pkg::PULSE_W-1:0]    i_cfg_data,
    output qxm_pkg::t_cfg                  o_cfg
);
    import qxm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pulse   <= PULSE_W'(1000);
            r_cfg.max_pulse   <= PULSE_W'(2000);
            r_cfg.thr_floor   <= PULSE_W'(1100);
            r_cfg.thr_ceiling <= PULSE_W'(1600);
            r_cfg.corr_limit  <= CORR_W'(100);
            r_cfg.mix_floor   <= PULSE_W'(1100);
            r_cfg.mix_ceiling <= PULSE_W'(2000);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_PULSE:   r_cfg.min_pulse   <= i_cfg_data;
                CFG_MAX_PULSE:   r_cfg.max_pulse   <= i_cfg_data;
                CFG_THR_FLOOR:   r_cfg.thr_floor   <= i_cfg_data;
                CFG_THR_CEILING: r_cfg.thr_ceiling <= i_cfg_data;
                CFG_CORR_LIMIT:  r_cfg.corr_limit  <= i_cfg_data[CORR_W-1:0];
                CFG_MIX_FLOOR:   r_cfg.mix_floor   <= i_cfg_data;
                CFG_MIX_CEILING: r_cfg.mix_ceiling <= i_cfg_data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

endmodule

FILE: sv/qxm_mix.sv
// Input register, arming gate, clamps and quad-X mixing down to four pulse widths.
module qxm_mix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qxm_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [qxm_pkg::OP_W-1:0]          i_op,
    input  logic signed [qxm_pkg::CMD_W-1:0]  i_throttle,
    input  logic signed [qxm_pkg::CMD_W-1:0]  i_pitch,
    input  logic signed [qxm_pkg::CMD_W-1:0]  i_roll,
    input  logic signed [qxm_pkg::CMD_W-1:0]  i_yaw,
    output logic                              o_valid,
    input  logic                              i_ready,
    output qxm_pkg::t_pulse_set               o_pulse
);
    import qxm_pkg::*;

    // stage 0: input register
    logic                     r_s0_valid;
    logic [OP_W-1:0]          r_s0_op;
    logic signed [CMD_W-1:0]  r_s0_thr, r_s0_pitch, r_s0_roll, r_s0_yaw;
    // stage 1: pulse register
    logic                     r_s1_valid;
    t_pulse_set               r_s1;
    logic                     r_armed;

    logic       s0_go, s1_ready, s0_emits, n_armed;
    t_pulse_set n_s1;
    t_mix       thr, pc, rc, yc, lim;

    function automatic logic [PULSE_W-1:0] motor_pulse(input t_mix sum, input t_cfg c,
                                                       input logic armed);
        t_mix m;
        t_mix q;
        m = clamp_s(sum, from_pulse(c.mix_floor), from_pulse(c.mix_ceiling));
        q = clamp_s(m, from_pulse(c.min_pulse), from_pulse(c.max_pulse));
        return armed ? q[PULSE_W-1:0] : c.min_pulse;
    endfunction

    assign s1_ready = !r_s1_valid || i_ready;
    assign s0_go    = r_s0_valid && s1_ready;
    assign o_ready  = !r_s0_valid || s1_ready;
    assign o_valid  = r_s1_valid;
    assign o_pulse  = r_s1;

    always_comb begin
        lim = $signed({{(MIX_W-CORR_W){1'b0}}, i_cfg.corr_limit});
        thr = clamp_s($signed({r_s0_thr[CMD_W-1], r_s0_thr}),
                      from_pulse(i_cfg.thr_floor), from_pulse(i_cfg.thr_ceiling));
        pc  = clamp_s($signed({r_s0_pitch[CMD_W-1], r_s0_pitch}), -lim, lim);
        rc  = clamp_s($signed({r_s0_roll[CMD_W-1], r_s0_roll}), -lim, lim);
        yc  = clamp_s($signed({r_s0_yaw[CMD_W-1], r_s0_yaw}), -lim, lim);
    end

    always_comb begin
        n_armed  = r_armed;
        s0_emits = 1'b0;
        n_s1     = r_s1;
        case (r_s0_op)
            OP_MIX: begin
                s0_emits         = 1'b1;
                n_s1.front_left  = motor_pulse(thr + pc + rc + yc, i_cfg, r_armed);
                n_s1.front_right = motor_pulse(thr + pc - rc - yc, i_cfg, r_armed);
                n_s1.rear_left   = motor_pulse(thr - pc + rc - yc, i_cfg, r_armed);
                n_s1.rear_right  = motor_pulse(thr - pc - rc + yc, i_cfg, r_armed);
                n_s1.armed       = r_armed;
            end
            OP_ARM: begin
                n_armed = 1'b1;
            end
            OP_STOP: begin
                s0_emits         = 1'b1;
                n_armed          = 1'b0;
                n_s1.front_left  = i_cfg.min_pulse;
                n_s1.front_right = i_cfg.min_pulse;
                n_s1.rear_left   = i_cfg.min_pulse;
                n_s1.rear_right  = i_cfg.min_pulse;
                n_s1.armed       = 1'b0;
            end
            default: ;  // unused code: no result, no state change
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_armed    <= 1'b0;
        end else begin
            if (o_ready) r_s0_valid <= i_valid;
            if (s1_ready) r_s1_valid <= s0_go && s0_emits;
            if (s0_go) r_armed <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s0_op    <= i_op;
            r_s0_thr   <= i_throttle;
            r_s0_pitch <= i_pitch;
            r_s0_roll  <= i_roll;
            r_s0_yaw   <= i_yaw;
        end
        if (s0_go && s0_emits) r_s1 <= n_s1;
    end

    a_arm_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_go && r_s0_op == OP_ARM) |=> r_armed)
        else $error("arm request did not set the armed flag");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s0_go && r_s0_op == OP_STOP) |=> (!r_armed && r_s1_valid && !r_s1.armed))
        else $error("stop request did not disarm");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_ready) |=> (r_s1_valid && $stable(r_s1)))
        else $error("pulse stage changed while stalled");

endmodule

FILE: sv/qxm_duty.sv
// Pulse-width to PWM duty conversion, four lanes, two registered stages.
module qxm_duty (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  qxm_pkg::t_pulse_set           i_pulse,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qxm_pkg::DUTY_W-1:0]    o_duty [4],
    output logic                          o_armed
);
    import qxm_pkg::*;

    // stage A: rounded numerator; stage B: quotient, limited (output register)
    logic                r_a_valid;
    logic [NUM_W-1:0]    r_a_num [4];
    logic                r_a_armed;
    logic                r_b_valid;
    logic [DUTY_W-1:0]   r_b_duty [4];
    logic                r_b_armed;

    logic                a_ready, b_ready;
    logic [PULSE_W-1:0]  pulse [4];
    logic [NUM_W-1:0]    n_a_num [4];
    logic [DUTY_W-1:0]   n_b_duty [4];

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_duty  = r_b_duty;
    assign o_armed = r_b_armed;

    assign pulse[0] = i_pulse.front_left;
    assign pulse[1] = i_pulse.front_right;
    assign pulse[2] = i_pulse.rear_left;
    assign pulse[3] = i_pulse.rear_right;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_a_num[k] = NUM_W'(pulse[k]) * NUM_W'(TWO_DMAX) + NUM_W'(FRAME_PERIOD_US);
        end
    end

    always_comb begin
        logic [PROD_W-1:0] prod;
        logic [31:0]       q;
        for (int k = 0; k < 4; k++) begin
            prod = PROD_W'(r_a_num[k]) * PROD_W'(RECIP);
            q    = 32'(prod[PROD_W-1:SHIFT]);
            if (q > 32'(DUTY_MAX)) q = 32'(DUTY_MAX);
            n_b_duty[k] = q[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_num   <= n_a_num;
            r_a_armed <= i_pulse.armed;
        end
        if (b_ready && r_a_valid) begin
            r_b_duty  <= n_b_duty;
            r_b_armed <= r_a_armed;
        end
    end

    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (32'(r_b_duty[0]) <= 32'(DUTY_MAX) && 32'(r_b_duty[1]) <= 32'(DUTY_MAX)
                    && 32'(r_b_duty[2]) <= 32'(DUTY_MAX) && 32'(r_b_duty[3]) <= 32'(DUTY_MAX)))
        else $error("duty above full scale");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && b_ready) |=> r_b_valid)
        else $error("numerator stage lost a request");

endmodule

FILE: sv/quad_x_mixer_pwm_duty.sv
// Top level of the quad-X motor mixer with arming gate and PWM duty output.
// Each request on the slave stream carries an operation in tuser: mix, arm or
// stop. Arm sets the armed flag and returns nothing; stop clears it and returns
// the minimum pulse as duty on all four motors; mix clamps throttle to the
// throttle window and pitch/roll/yaw to +/- correction_limit, forms the four
// quad-X sums (FL = t+p+r+y, FR = t+p-r-y, RL = t-p+r-y, RR = t-p-r+y), clamps
// each sum to the mix window and then to [min_pulse, max_pulse], or forces the
// minimum pulse when disarmed. Every clamp checks its lower bound first. A pulse
// p becomes duty = p*(2^14-1)/20000 rounded to nearest, ties up. The unused
// operation code is dropped. A request takes four registers from input to result
// (input, pulse, numerator, output); one request per cycle is sustained while
// results are taken, and each pipeline stage refills as soon as its content moves
// on, so requests keep flowing while a finished result waits until every stage
// is full; then the input stalls.
// Configuration registers (index: name, reset):
// 0 min_pulse 1000, 1 max_pulse 2000, 2 throttle_floor 1100, 3 throttle_ceiling
// 1600, 4 correction_limit 100 (10 bits), 5 mix_floor 1100, 6 mix_ceiling 2000;
// other indexes are ignored. Write them only while no request is in flight.
module quad_x_mixer_pwm_duty (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qxm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qxm_pkg::PULSE_W-1:0]     i_cfg_data,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [63:0]                     s_axis_tdata,  // throttle_us, pitch_corr,
                                                           // roll_corr, yaw_corr
    input  logic [1:0]                      s_axis_tuser,  // operation
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [55:0]                     m_axis_tdata,  // duty_front_left,
                                                           // duty_front_right,
                                                           // duty_rear_left,
                                                           // duty_rear_right
    output logic                            m_axis_tuser   // motors_armed
);
    import qxm_pkg::*;

    t_cfg               cfg;
    t_pulse_set         pulse;
    logic               pulse_valid, pulse_ready;
    logic [DUTY_W-1:0]  duty [4];

    qxm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // clamps and mixing; also owns the armed flag
    qxm_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_throttle ($signed(s_axis_tdata[15:0])),
        .i_pitch    ($signed(s_axis_tdata[31:16])),
        .i_roll     ($signed(s_axis_tdata[47:32])),
        .i_yaw      ($signed(s_axis_tdata[63:48])),
        .o_valid    (pulse_valid),
        .i_ready    (pulse_ready),
        .o_pulse    (pulse)
    );

    // microseconds to duty counts, output register inside
    qxm_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pulse_valid),
        .o_ready (pulse_ready),
        .i_pulse (pulse),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_duty  (duty),
        .o_armed (m_axis_tuser)
    );

    assign m_axis_tdata = {duty[3], duty[2], duty[1], duty[0]};

endmodule
